>>> src/dpm_power_state_policy_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the power state policy core
// Shared clocked assertion forms, reset-qualified on rst.
// ----------------------------------------------------------------------------
`ifndef DPM_POWER_STATE_POLICY_CORE_MACROS_SVH
`define DPM_POWER_STATE_POLICY_CORE_MACROS_SVH

// prop must hold at every edge outside reset
`define DPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expr must never be true outside reset
`define DPM_ASSERT_NEVER(lbl, expr, msg) \
  `DPM_ASSERT(lbl, !(expr), msg)

`endif

>>> src/dpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_pkg
// Types and constants shared by the power state policy core.
// ----------------------------------------------------------------------------
package dpm_pkg;

  localparam int IDLE_LENGTH_BITS = 16;
  localparam int COEF_W           = 32;
  localparam int LEVEL_W          = 32;
  localparam int HORNER_W         = 40;
  localparam int MUL_X_W          = IDLE_LENGTH_BITS + 1;
  localparam int PROD_W           = HORNER_W + MUL_X_W;
  localparam int SUM_W            = PROD_W + 1;
  localparam int QUEUE_DEPTH      = 2;
  localparam int CFG_INDEX_W      = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_LOW     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_HIGH    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COEF_CUBIC    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_COEF_SQUARE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_COEF_LINEAR   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_COEF_CONSTANT = 3'd6;

  localparam logic MODE_TIMEOUT = 1'b0;
  localparam logic MODE_PREDICT = 1'b1;

  typedef enum logic [1:0] {
    PS_ACTIVE = 2'd0,
    PS_IDLE   = 2'd1,
    PS_SLEEP  = 2'd2
  } power_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ADD_SQ,
    BK_MUL_LIN,
    BK_ADD_LIN,
    BK_MUL_CON,
    BK_ADD_CON,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic                        in_active_period;
    logic [IDLE_LENGTH_BITS-1:0] idle_length;
  } dpm_in_t;

  typedef struct packed {
    power_state_t power_state;
    logic         state_changed;
    logic         waiting;
  } dpm_out_t;

  typedef struct packed {
    logic               mode;
    logic [LEVEL_W-1:0] level_low;
    logic [LEVEL_W-1:0] level_high;
    logic [COEF_W-1:0]  coef_cubic;
    logic [COEF_W-1:0]  coef_square;
    logic [COEF_W-1:0]  coef_linear;
    logic [COEF_W-1:0]  coef_constant;
  } cfg_regs_t;

  typedef struct packed {
    logic                        in_active_period;
    logic                        predict;
    power_state_t                state;
    logic [IDLE_LENGTH_BITS-1:0] idle_length;
  } queue_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

>>> src/dpm_power_state_policy_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_power_state_policy_core
// Per-tick power state policy: timeout counting or cubic idle prediction.
// ----------------------------------------------------------------------------
// channel  signals                                  beat
// in       in_valid / in_ready / in_data            one tick sample
// out      out_valid / out_ready / out_data         one state decision
// cfg      cfg_valid / cfg_ready / cfg_index+data   one register write
//
// Active-period and timeout ticks: one beat per cycle unless out, the queue or a
// running prediction stalls them. Predictive idle ticks: the back end runs three
// Horner multiply/add steps on the shared 40x17 multiplier, one tick at a time.
// Sync reset clears config, idle counter, last state (active) and queue.
// A two-entry queue lets the front keep accepting while out is stalled.
// ----------------------------------------------------------------------------
`include "dpm_power_state_policy_core_macros.svh"

module dpm_power_state_policy_core #(
  parameter int ELAPSED_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dpm_pkg::dpm_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dpm_pkg::dpm_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dpm_pkg::COEF_W-1:0]          cfg_data
);
  import dpm_pkg::*;

  cfg_regs_t     cfg;
  queue_status_t q_status;
  queue_entry_t  push_entry;
  queue_entry_t  head;
  logic          push;
  logic          pop;
  logic          out_wait_bad;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:          cfg.mode          <= cfg_data[0];
        CFG_LEVEL_LOW:     cfg.level_low     <= cfg_data;
        CFG_LEVEL_HIGH:    cfg.level_high    <= cfg_data;
        CFG_COEF_CUBIC:    cfg.coef_cubic    <= cfg_data;
        CFG_COEF_SQUARE:   cfg.coef_square   <= cfg_data;
        CFG_COEF_LINEAR:   cfg.coef_linear   <= cfg_data;
        CFG_COEF_CONSTANT: cfg.coef_constant <= cfg_data;
        default: ;
      endcase
    end
  end

  dpm_front #(
    .ELAPSED_BITS(ELAPSED_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  dpm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  dpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_wait_bad = out_valid && out_data.waiting && (out_data.power_state != PS_ACTIVE);

  `DPM_ASSERT_NEVER(a_q_overflow, push && q_status.full && !pop, "queue overflow")
  `DPM_ASSERT_NEVER(a_q_underflow, pop && q_status.empty, "queue underflow")
  `DPM_ASSERT_NEVER(a_waiting_state, out_wait_bad, "waiting while not active")

endmodule

>>> src/dpm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_queue
// Short FIFO of classified ticks between front and back.
// ----------------------------------------------------------------------------
module dpm_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dpm_pkg::queue_entry_t push_entry,
  input  logic                  pop,
  output dpm_pkg::queue_entry_t head,
  output dpm_pkg::queue_status_t status
);
  import dpm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  queue_entry_t     entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_FULL);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> src/dpm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_front
// Accepts ticks, tracks idle time and settles timeout decisions.
// ----------------------------------------------------------------------------
module dpm_front #(
  parameter int ELAPSED_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dpm_pkg::cfg_regs_t     cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dpm_pkg::dpm_in_t       in_data,
  input  dpm_pkg::queue_status_t q_status,
  output logic                   push,
  output dpm_pkg::queue_entry_t  push_entry
);
  import dpm_pkg::*;

  localparam int CMP_W = (ELAPSED_BITS > LEVEL_W) ? ELAPSED_BITS : LEVEL_W;

  logic [ELAPSED_BITS-1:0] idle_elapsed;
  logic [CMP_W-1:0]        el_ext;
  logic                    over_low;
  logic                    over_high;
  power_state_t            timeout_state;

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  assign el_ext    = CMP_W'(idle_elapsed);
  assign over_low  = el_ext > CMP_W'(cfg.level_low);
  assign over_high = el_ext > CMP_W'(cfg.level_high);

  always_comb begin
    if (!over_low) begin
      timeout_state = PS_ACTIVE;
    end else if (over_high) begin
      timeout_state = PS_SLEEP;
    end else begin
      timeout_state = PS_IDLE;
    end
  end

  always_comb begin
    push_entry.in_active_period = in_data.in_active_period;
    push_entry.idle_length      = in_data.idle_length;
    push_entry.predict          = !in_data.in_active_period && (cfg.mode == MODE_PREDICT);
    push_entry.state            = in_data.in_active_period ? PS_ACTIVE : timeout_state;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_elapsed <= '0;
    end else if (push) begin
      if (in_data.in_active_period) begin
        idle_elapsed <= '0;
      end else if (idle_elapsed != '1) begin
        idle_elapsed <= idle_elapsed + ELAPSED_BITS'(1);
      end
    end
  end

endmodule

>>> src/dpm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_back
// Horner cubic on one shared multiplier, final decision, result register.
// ----------------------------------------------------------------------------
module dpm_back (
  input  logic                   clk,
  input  logic                   rst,
  input  dpm_pkg::cfg_regs_t     cfg,
  input  dpm_pkg::queue_status_t q_status,
  input  dpm_pkg::queue_entry_t  head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dpm_pkg::dpm_out_t      out_data
);
  import dpm_pkg::*;

  localparam logic signed [SUM_W-1:0] CLAMP_POS = SUM_W'(64'sd1 <<< 38);
  localparam logic signed [SUM_W-1:0] CLAMP_NEG = -CLAMP_POS;
  localparam logic signed [SUM_W-1:0] Q_MAX     = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] Q_MIN     = -Q_MAX - SUM_W'(1);

  function automatic logic signed [HORNER_W-1:0] clamp_horner(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] r;
    r = v;
    if (v > CLAMP_POS) begin
      r = CLAMP_POS;
    end else if (v < CLAMP_NEG) begin
      r = CLAMP_NEG;
    end
    return r[HORNER_W-1:0];
  endfunction

  function automatic logic signed [COEF_W-1:0] sat_q16(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] r;
    r = v;
    if (v > Q_MAX) begin
      r = Q_MAX;
    end else if (v < Q_MIN) begin
      r = Q_MIN;
    end
    return r[COEF_W-1:0];
  endfunction

  back_state_t                  state;
  back_state_t                  state_next;
  power_state_t                 current_state;
  logic signed [HORNER_W-1:0]   acc;
  logic signed [HORNER_W-1:0]   acc_next;
  logic [IDLE_LENGTH_BITS-1:0]  x_reg;
  logic signed [PROD_W-1:0]     prod;
  logic signed [COEF_W-1:0]     poly;
  logic signed [COEF_W-1:0]     poly_next;
  logic signed [HORNER_W-1:0]   mul_a;
  logic signed [MUL_X_W-1:0]    mul_x;
  logic signed [PROD_W-1:0]     mul_p;
  logic                         mul_en;
  logic [COEF_W-1:0]            add_coef;
  logic signed [SUM_W-1:0]      sum;
  logic                         can_load;
  logic                         out_load;
  power_state_t                 load_state;
  logic                         load_waiting;
  power_state_t                 pred_state;
  logic                         p_nonneg;

  assign can_load = !out_valid || out_ready;

  always_comb begin
    if (state == BK_IDLE) begin
      mul_a = {{(HORNER_W-COEF_W){cfg.coef_cubic[COEF_W-1]}}, cfg.coef_cubic};
      mul_x = {1'b0, head.idle_length};
    end else begin
      mul_a = acc;
      mul_x = {1'b0, x_reg};
    end
  end
  assign mul_p = mul_a * mul_x;

  always_comb begin
    unique case (state)
      BK_ADD_SQ:  add_coef = cfg.coef_square;
      BK_ADD_LIN: add_coef = cfg.coef_linear;
      default:    add_coef = cfg.coef_constant;
    endcase
  end
  assign sum = {prod[PROD_W-1], prod} + {{(SUM_W-COEF_W){add_coef[COEF_W-1]}}, add_coef};

  assign p_nonneg = !poly[COEF_W-1];
  always_comb begin
    if (p_nonneg && ({1'b0, poly[COEF_W-2:0]} > cfg.level_high)) begin
      pred_state = PS_SLEEP;
    end else if (p_nonneg && ({1'b0, poly[COEF_W-2:0]} > cfg.level_low)) begin
      pred_state = PS_IDLE;
    end else begin
      pred_state = PS_ACTIVE;
    end
  end

  always_comb begin
    state_next   = state;
    pop          = 1'b0;
    mul_en       = 1'b0;
    out_load     = 1'b0;
    acc_next     = acc;
    poly_next    = poly;
    load_state   = head.state;
    load_waiting = (head.state == PS_ACTIVE) && !head.in_active_period;
    unique case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          if (head.predict) begin
            pop        = 1'b1;
            mul_en     = 1'b1;
            state_next = BK_ADD_SQ;
          end else if (can_load) begin
            pop      = 1'b1;
            out_load = 1'b1;
          end
        end
      end
      BK_ADD_SQ: begin
        acc_next   = clamp_horner(sum);
        state_next = BK_MUL_LIN;
      end
      BK_MUL_LIN: begin
        mul_en     = 1'b1;
        state_next = BK_ADD_LIN;
      end
      BK_ADD_LIN: begin
        acc_next   = clamp_horner(sum);
        state_next = BK_MUL_CON;
      end
      BK_MUL_CON: begin
        mul_en     = 1'b1;
        state_next = BK_ADD_CON;
      end
      BK_ADD_CON: begin
        poly_next  = sat_q16(sum);
        state_next = BK_DONE;
      end
      BK_DONE: begin
        load_state   = pred_state;
        load_waiting = (pred_state == PS_ACTIVE);
        if (can_load) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      current_state <= PS_ACTIVE;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        current_state <= load_state;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc  <= acc_next;
    poly <= poly_next;
    if (mul_en) begin
      prod <= mul_p;
    end
    if (pop) begin
      x_reg <= head.idle_length;
    end
    if (out_load) begin
      out_data.power_state   <= load_state;
      out_data.state_changed <= (load_state != current_state);
      out_data.waiting       <= load_waiting;
    end
  end

endmodule

>>> sim/dpm_power_state_policy_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_power_state_policy_core_test
// Self-checking bench for the power state policy core. Ticks go in over a
// valid/ready channel in bursts. A shadow of the policy predicts each state
// decision, covering timeout counting and the saturated cubic prediction.
// Every output beat is compared field by field against that prediction.
// Both policies are run under directed and random register settings, with
// random stalls on the output side.
// ----------------------------------------------------------------------------
module dpm_power_state_policy_core_test;
  import dpm_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
  localparam longint HORNER_LIM = 64'sd1 <<< 38;
  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;
  localparam longint unsigned ELAPSED_MAX = (64'd1 << 32) - 1;

  class policy_shadow;
    cfg_regs_t      cfg;
    longint unsigned idle_ticks;
    power_state_t   last_state;
    dpm_out_t       pending_decisions[$];
    int             mismatches;
    int             beats_seen;

    function new();
      cfg = '0;
      idle_ticks = 0;
      last_state = PS_ACTIVE;
      mismatches = 0;
      beats_seen = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [COEF_W-1:0] v);
      case (idx)
        CFG_MODE:          cfg.mode = v[0];
        CFG_LEVEL_LOW:     cfg.level_low = v;
        CFG_LEVEL_HIGH:    cfg.level_high = v;
        CFG_COEF_CUBIC:    cfg.coef_cubic = v;
        CFG_COEF_SQUARE:   cfg.coef_square = v;
        CFG_COEF_LINEAR:   cfg.coef_linear = v;
        CFG_COEF_CONSTANT: cfg.coef_constant = v;
        default: ;
      endcase
    endfunction

    function longint clamp_horner(longint v);
      if (v > HORNER_LIM) return HORNER_LIM;
      if (v < -HORNER_LIM) return -HORNER_LIM;
      return v;
    endfunction

    function longint eval_poly(logic [IDLE_LENGTH_BITS-1:0] x);
      longint xs;
      longint h;
      xs = x;
      h = clamp_horner(longint'($signed(cfg.coef_cubic)) * xs
                       + longint'($signed(cfg.coef_square)));
      h = clamp_horner(h * xs + longint'($signed(cfg.coef_linear)));
      h = h * xs + longint'($signed(cfg.coef_constant));
      if (h > Q_HI) h = Q_HI;
      else if (h < Q_LO) h = Q_LO;
      return h;
    endfunction

    function power_state_t classify_tick(dpm_in_t t);
      longint p;
      power_state_t nxt;
      nxt = PS_ACTIVE;
      if (t.in_active_period) begin
        idle_ticks = 0;
      end else begin
        if (cfg.mode == MODE_TIMEOUT) begin
          if (idle_ticks > cfg.level_low)
            nxt = (idle_ticks > cfg.level_high) ? PS_SLEEP : PS_IDLE;
        end else begin
          p = eval_poly(t.idle_length);
          if (p > longint'({32'd0, cfg.level_high})) nxt = PS_SLEEP;
          else if (p > longint'({32'd0, cfg.level_low})) nxt = PS_IDLE;
        end
        if (idle_ticks < ELAPSED_MAX) idle_ticks++;
      end
      return nxt;
    endfunction

    function void note_tick(dpm_in_t t);
      dpm_out_t e;
      power_state_t nxt;
      nxt = classify_tick(t);
      e.power_state = nxt;
      e.state_changed = (nxt != last_state);
      e.waiting = (nxt == PS_ACTIVE) && !t.in_active_period;
      last_state = nxt;
      pending_decisions.push_back(e);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 30) $display("MISMATCH beat %0d: %s", beats_seen, msg);
    endtask

    task check_decision(dpm_out_t got);
      dpm_out_t e;
      if (pending_decisions.size() == 0) begin
        report($sformatf("unexpected beat %b", got));
      end else begin
        e = pending_decisions.pop_front();
        if (got.power_state !== e.power_state)
          report($sformatf("power_state got %0d want %0d", got.power_state, e.power_state));
        if (got.state_changed !== e.state_changed)
          report($sformatf("state_changed got %b want %b", got.state_changed,
                           e.state_changed));
        if (got.waiting !== e.waiting)
          report($sformatf("waiting got %b want %b", got.waiting, e.waiting));
      end
      beats_seen++;
    endtask

    function int pending();
      return pending_decisions.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  dpm_in_t                in_data;
  logic                   out_valid;
  logic                   out_ready;
  dpm_out_t               out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [COEF_W-1:0]      cfg_data;

  policy_shadow sb;
  int burst_left;
  int ready_left;
  int ready_mode;
  int ready_tick;

  dpm_power_state_policy_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(16, 96);
    end else begin
      ready_left--;
    end
    ready_tick++;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ready_tick[1];
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_tick(in_data);
      if (out_valid && out_ready) sb.check_decision(out_data);
    end
  end

  task automatic idle_in(int n);
    logic [31:0] junk;
    repeat (n) begin
      junk = $urandom;
      @(negedge clk);
      in_valid <= 1'b0;
      in_data <= dpm_in_t'(junk[$bits(dpm_in_t)-1:0]);
    end
  endtask

  task automatic send_tick(bit act, logic [IDLE_LENGTH_BITS-1:0] x);
    dpm_in_t d;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) idle_in(gap);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    d.in_active_period = act;
    d.idle_length = x;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [COEF_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold off the sender until every decision is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [IDLE_LENGTH_BITS-1:0] pick_idle_length();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return IDLE_LENGTH_BITS'($urandom_range(0, 255));
      default: return IDLE_LENGTH_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    int v;
    case ($urandom_range(0, 4))
      0: return '0;
      1: begin
        v = int'($urandom_range(0, 1 << 20)) - (1 << 19);
        return v;
      end
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_config();
    logic              m;
    logic [LEVEL_W-1:0] lo;
    logic [LEVEL_W-1:0] hi;
    logic [COEF_W-1:0]  mode_word;
    m = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 5) == 0) begin
      lo = $urandom_range(0, 1) ? '1 : '0;
      hi = $urandom_range(0, 1) ? '1 : '0;
    end else if (m == MODE_TIMEOUT) begin
      lo = $urandom_range(0, 20);
      hi = $urandom_range(0, 40);
    end else if ($urandom_range(0, 1)) begin
      lo = $urandom_range(0, 32'h0040_0000);
      hi = LEVEL_W'(lo + $urandom_range(0, 32'h0040_0000));
    end else begin
      lo = $urandom;
      hi = $urandom;
    end
    mode_word = $urandom;
    mode_word[0] = m;
    set_reg(CFG_MODE, mode_word);
    set_reg(CFG_LEVEL_LOW, lo);
    set_reg(CFG_LEVEL_HIGH, hi);
    set_reg(CFG_COEF_CUBIC, pick_coef());
    set_reg(CFG_COEF_SQUARE, pick_coef());
    set_reg(CFG_COEF_LINEAR, pick_coef());
    set_reg(CFG_COEF_CONSTANT, pick_coef());
    if ($urandom_range(0, 3) == 0) set_reg(CFG_UNUSED, $urandom);
  endtask

  // mostly active runs followed by idle periods, some scattered noise
  task automatic run_random(int n);
    int sent;
    int k;
    int len;
    int pause_at;
    bit paused;
    sent = 0;
    paused = 1'b0;
    pause_at = $urandom_range(n / 4, 3 * n / 4);
    while (sent < n) begin
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) send_tick(1'($urandom_range(0, 1)), pick_idle_length());
        sent += len;
      end else begin
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) send_tick(1'b1, pick_idle_length());
        sent += len;
        len = $urandom_range(1, 50);
        for (k = 0; k < len; k++) send_tick(1'b0, pick_idle_length());
        sent += len;
      end
      if (!paused && sent >= pause_at) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    #5ms;
    $display("dpm_power_state_policy_core test failed");
    $finish;
  end

  initial begin
    int ph;
    int k;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    burst_left = 0;
    ready_left = 0;
    ready_mode = 0;
    ready_tick = 0;
    sb = new();
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: timeout policy, both levels zero
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b0, 16'h0000);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b1, 16'h0000);

    drain();
    set_reg(CFG_LEVEL_LOW, 32'd2);
    set_reg(CFG_LEVEL_HIGH, 32'd4);
    for (k = 0; k < 6; k++) send_tick(1'b0, 16'h00A5);
    send_tick(1'b1, 16'h5A00);

    // levels out of order: straight to sleep past the low level
    drain();
    set_reg(CFG_LEVEL_LOW, 32'd1);
    set_reg(CFG_LEVEL_HIGH, 32'd0);
    for (k = 0; k < 3; k++) send_tick(1'b0, 16'h1234);
    send_tick(1'b1, 16'h0001);

    // prediction saturating at the top
    drain();
    set_reg(CFG_MODE, {31'd0, MODE_PREDICT});
    set_reg(CFG_COEF_CUBIC, 32'h7FFF_FFFF);
    set_reg(CFG_COEF_SQUARE, 32'h0000_0000);
    set_reg(CFG_COEF_LINEAR, 32'h0000_0000);
    set_reg(CFG_COEF_CONSTANT, 32'h0000_0000);
    set_reg(CFG_LEVEL_LOW, 32'h0000_0000);
    set_reg(CFG_LEVEL_HIGH, 32'hFFFF_FFFF);
    send_tick(1'b0, 16'h0000);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b1, 16'hFFFF);
    drain();
    set_reg(CFG_LEVEL_HIGH, 32'h7FFF_FFFE);
    send_tick(1'b0, 16'hFFFF);

    // alternating extreme coefficients, Horner clamp and negative saturation
    drain();
    set_reg(CFG_COEF_CUBIC, 32'h8000_0000);
    set_reg(CFG_COEF_SQUARE, 32'h7FFF_FFFF);
    set_reg(CFG_COEF_LINEAR, 32'h8000_0000);
    set_reg(CFG_COEF_CONSTANT, 32'h7FFF_FFFF);
    set_reg(CFG_UNUSED, $urandom);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b0, 16'h0001);
    send_tick(1'b0, 16'h0000);

    for (ph = 0; ph < 10; ph++) begin
      drain();
      random_config();
      run_random(180);
    end

    drain();
    if (sb.pending() != 0) sb.report("decisions still outstanding");
    if (sb.mismatches == 0) begin
      $display("dpm_power_state_policy_core test passed");
    end else begin
      $display("dpm_power_state_policy_core test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/dpm_pkg.sv
src/dpm_queue.sv
src/dpm_front.sv
src/dpm_back.sv
src/dpm_power_state_policy_core.sv
sim/dpm_power_state_policy_core_test.sv
